### src/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// Constants, types and the rotate helper function shared by the XXH64 block.
// ----------------------------------------------------------------------------
package xxh_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,     // load lanes and clear counters from the seed
    OP_WRITE,    // store one input byte
    OP_RMUL,     // lane k: t = acc + word*P2
    OP_RFIN,     // lane k: acc = rotl(t,31)*P1
    OP_MSTART,   // h = rotl sum of lanes, or seed + P5
    OP_MMUL,     // t = rotl(acc_k * P2, 31)
    OP_MFIN,     // h = (h ^ t*P1) * P1 + P4
    OP_LEN,      // h += length
    OP_W8A,      // t = rotl(word*P2, 31)
    OP_W8B,      // t = h ^ t*P1
    OP_W8C,      // h = rotl(t,27)*P1 + P4
    OP_W4,       // t = h ^ word4*P1, then h = rotl(t,23)*P2 + P3
    OP_B1,       // t = h ^ byte*P5, then h = rotl(t,11)*P1
    OP_AVA,      // avalanche step
    OP_OUT       // copy the finished hash into the output register
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] lane;
    logic [1:0] phase;
    logic [7:0] byte_val;
  } cmd_t;

  typedef struct packed {
    logic [5:0] buf_cnt;
    logic [5:0] pos;
    logic       len_zero;
    logic       long_msg;
  } status_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

endpackage

### src/xxh_if.sv
// ----------------------------------------------------------------------------
// xxh_in_if / xxh_out_if
// Valid/ready channels for message items and hash results.
// ----------------------------------------------------------------------------
interface xxh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_bytes;
  logic [3:0]  byte_count;
  logic        last_item;
  modport source (output valid, data_bytes, byte_count, last_item, input ready);
  modport sink (input valid, data_bytes, byte_count, last_item, output ready);
endinterface

interface xxh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

### src/xxh_datapath.sv
// ----------------------------------------------------------------------------
// xxh_datapath
// Lanes, stripe buffer, length counter and the shared multi-cycle multiplier.
// ----------------------------------------------------------------------------
module xxh_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [63:0]      seed_i,
  input  xxh_pkg::cmd_t    cmd_i,
  output xxh_pkg::status_t status_o,
  output logic             busy_o,
  output logic [63:0]      hash_o
);

  logic [7:0]  buf_q [32];
  logic [63:0] acc_q [4];
  logic [63:0] seed_q, len_q, h_q, t_q, hash_q;
  logic [5:0]  cnt_q, pos_q;

  logic [63:0] word8, word4, mul_a, mul_b, prod;
  logic [4:0]  base;

  // The low 64 bits of a product are built from three 32x32 partial products,
  // one per cycle; the command is held until the last one is in.
  logic        need_mul;
  logic [1:0]  mcyc_q;
  logic [63:0] mpart_q;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  always_comb begin
    base = (cmd_i.op == xxh_pkg::OP_RMUL) ? {cmd_i.lane, 3'd0} : pos_q[4:0];
    word8 = '0;
    for (int i = 0; i < 8; i++) word8[8*i +: 8] = buf_q[5'(base + 5'(i))];
    word4 = {32'd0, word8[31:0]};
  end

  always_comb begin
    mul_a = t_q;
    mul_b = xxh_pkg::P1;
    unique case (cmd_i.op)
      xxh_pkg::OP_RMUL, xxh_pkg::OP_W8A: begin
        mul_a = word8; mul_b = xxh_pkg::P2;
      end
      xxh_pkg::OP_RFIN, xxh_pkg::OP_MFIN, xxh_pkg::OP_W8B: begin
        mul_a = (cmd_i.op == xxh_pkg::OP_RFIN) ? xxh_pkg::rotl(t_q, 31) : t_q;
      end
      xxh_pkg::OP_MMUL: begin
        mul_a = acc_q[cmd_i.lane]; mul_b = xxh_pkg::P2;
      end
      xxh_pkg::OP_W8C: mul_a = xxh_pkg::rotl(t_q, 27);
      xxh_pkg::OP_W4: begin
        mul_a = cmd_i.phase[0] ? xxh_pkg::rotl(t_q, 23) : word4;
        mul_b = cmd_i.phase[0] ? xxh_pkg::P2 : xxh_pkg::P1;
      end
      xxh_pkg::OP_B1: begin
        mul_a = cmd_i.phase[0] ? xxh_pkg::rotl(t_q, 11) : {56'd0, buf_q[pos_q[4:0]]};
        mul_b = cmd_i.phase[0] ? xxh_pkg::P1 : xxh_pkg::P5;
      end
      xxh_pkg::OP_AVA: begin
        mul_a = t_q; mul_b = cmd_i.phase[1] ? xxh_pkg::P3 : xxh_pkg::P2;
      end
      default: ;
    endcase
  end

  assign need_mul = (cmd_i.op inside {xxh_pkg::OP_RMUL, xxh_pkg::OP_RFIN, xxh_pkg::OP_MMUL,
                                      xxh_pkg::OP_MFIN, xxh_pkg::OP_W8A, xxh_pkg::OP_W8B,
                                      xxh_pkg::OP_W8C, xxh_pkg::OP_W4, xxh_pkg::OP_B1}) ||
                    (cmd_i.op == xxh_pkg::OP_AVA && cmd_i.phase != 2'd0);

  // Low by low first, then the two cross terms, of which only the low half counts.
  always_comb begin
    case (mcyc_q)
      2'd0: begin
        mul_x = mul_a[31:0]; mul_y = mul_b[31:0];
      end
      2'd1: begin
        mul_x = mul_a[31:0]; mul_y = mul_b[63:32];
      end
      default: begin
        mul_x = mul_a[63:32]; mul_y = mul_b[31:0];
      end
    endcase
  end

  assign mul_p  = 64'(mul_x) * 64'(mul_y);
  assign prod   = mpart_q + {mul_p[31:0], 32'd0};
  assign busy_o = need_mul && (mcyc_q != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcyc_q  <= '0;
      mpart_q <= '0;
    end else if (need_mul) begin
      mcyc_q  <= (mcyc_q == 2'd2) ? 2'd0 : mcyc_q + 2'd1;
      mpart_q <= (mcyc_q == 2'd0) ? mul_p : prod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == xxh_pkg::OP_WRITE) buf_q[cnt_q[4:0]] <= cmd_i.byte_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      len_q  <= '0;
      cnt_q  <= '0;
      pos_q  <= '0;
      h_q    <= '0;
      t_q    <= '0;
      hash_q <= '0;
      acc_q[0] <= xxh_pkg::P1 + xxh_pkg::P2;
      acc_q[1] <= xxh_pkg::P2;
      acc_q[2] <= '0;
      acc_q[3] <= '0 - xxh_pkg::P1;
    end else if (!busy_o) begin
      unique case (cmd_i.op)
        xxh_pkg::OP_INIT: begin
          seed_q <= seed_i;
          len_q  <= '0;
          cnt_q  <= '0;
          acc_q[0] <= seed_i + xxh_pkg::P1 + xxh_pkg::P2;
          acc_q[1] <= seed_i + xxh_pkg::P2;
          acc_q[2] <= seed_i;
          acc_q[3] <= seed_i - xxh_pkg::P1;
        end
        xxh_pkg::OP_WRITE: begin
          cnt_q <= cnt_q + 6'd1;
          len_q <= len_q + 64'd1;
        end
        xxh_pkg::OP_RMUL: t_q <= acc_q[cmd_i.lane] + prod;
        xxh_pkg::OP_RFIN: begin
          acc_q[cmd_i.lane] <= prod;
          if (cmd_i.lane == 2'd3) cnt_q <= '0;
        end
        xxh_pkg::OP_MSTART: begin
          pos_q <= '0;
          if (len_q >= 64'd32)
            h_q <= xxh_pkg::rotl(acc_q[0], 1) + xxh_pkg::rotl(acc_q[1], 7) +
                   xxh_pkg::rotl(acc_q[2], 12) + xxh_pkg::rotl(acc_q[3], 18);
          else
            h_q <= seed_q + xxh_pkg::P5;
        end
        xxh_pkg::OP_MMUL: t_q <= xxh_pkg::rotl(prod, 31);
        xxh_pkg::OP_MFIN: begin
          if (cmd_i.phase[0]) h_q <= prod + xxh_pkg::P4;
          else t_q <= h_q ^ prod;
        end
        xxh_pkg::OP_LEN: h_q <= h_q + len_q;
        xxh_pkg::OP_W8A: t_q <= xxh_pkg::rotl(prod, 31);
        xxh_pkg::OP_W8B: t_q <= h_q ^ prod;
        xxh_pkg::OP_W8C: begin
          h_q <= prod + xxh_pkg::P4;
          pos_q <= pos_q + 6'd8;
        end
        xxh_pkg::OP_W4: begin
          if (cmd_i.phase[0]) begin
            h_q <= prod + xxh_pkg::P3;
            pos_q <= pos_q + 6'd4;
          end else t_q <= h_q ^ prod;
        end
        xxh_pkg::OP_B1: begin
          if (cmd_i.phase[0]) begin
            h_q <= prod;
            pos_q <= pos_q + 6'd1;
          end else t_q <= h_q ^ prod;
        end
        xxh_pkg::OP_AVA: begin
          // Phase 0 is the first xor-shift; phases 1 and 2 multiply, then xor-shift.
          unique case (cmd_i.phase)
            2'd0: t_q <= h_q ^ (h_q >> 33);
            2'd1: t_q <= (prod ^ (prod >> 29));
            2'd2: begin
              t_q <= prod ^ (prod >> 32);
            end
            default: ;
          endcase
        end
        xxh_pkg::OP_OUT: hash_q <= t_q;
        default: ;
      endcase
    end
  end

  assign status_o.buf_cnt  = cnt_q;
  assign status_o.pos      = pos_q;
  assign status_o.len_zero = (len_q == '0);
  assign status_o.long_msg = (len_q >= 64'd32);
  assign hash_o = hash_q;

endmodule

### src/xxh_ctrl.sv
// ----------------------------------------------------------------------------
// xxh_ctrl
// Sequencer for byte intake, stripe rounds and the digest.
// ----------------------------------------------------------------------------
module xxh_ctrl #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  xxh_in_if.sink           in_ch,
  xxh_out_if.source        out_ch,
  input  xxh_pkg::status_t status_i,
  input  logic             mul_busy_i,
  output xxh_pkg::cmd_t    cmd_o
);

  localparam int unsigned Limit = (BYTES_PER_ITEM < 8) ? BYTES_PER_ITEM : 8;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_BYTE  = 9'b000000010,
    S_ROUND = 9'b000000100,
    S_MERGE = 9'b000001000,
    S_W8    = 9'b000010000,
    S_W4    = 9'b000100000,
    S_B1    = 9'b001000000,
    S_AVA   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] data_q, data_d;
  logic [3:0]  cnt_q, cnt_d, idx_q, idx_d;
  logic        last_q, last_d;
  logic [3:0]  step_q, step_d;
  logic        init_q, init_d;
  logic        out_valid_q, out_valid_d;
  logic [5:0]  tail;
  logic [3:0]  sat;

  assign tail = {1'b0, status_i.buf_cnt[4:0]};
  assign sat  = (in_ch.byte_count > 4'(Limit)) ? 4'(Limit) : in_ch.byte_count;
  assign in_ch.ready  = (state_q == S_IDLE) && !init_q;
  assign out_ch.valid = out_valid_q;

  always_comb begin
    state_d = state_q;
    data_d  = data_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    last_d  = last_q;
    step_d  = step_q;
    init_d  = 1'b0;
    out_valid_d = out_valid_q && !out_ch.ready;
    cmd_o   = '{op: xxh_pkg::OP_NONE, lane: 2'd0, phase: 2'd0, byte_val: 8'd0};
    unique case (state_q)
      S_IDLE: begin
        if (init_q) cmd_o.op = xxh_pkg::OP_INIT;
        else if (in_ch.valid) begin
          data_d = in_ch.data_bytes;
          cnt_d = sat;
          idx_d = '0;
          last_d = in_ch.last_item;
          state_d = S_BYTE;
        end
        // A seed write right after a digest lands while the lanes are reloaded.
        if (cfg_we_i && (init_q || (status_i.len_zero && status_i.buf_cnt == '0)))
          init_d = 1'b1;
      end
      S_BYTE: begin
        if (status_i.buf_cnt == 6'd32) begin
          state_d = S_ROUND;
          step_d = '0;
        end else if (idx_q == cnt_q) begin
          state_d = last_q ? S_MERGE : S_IDLE;
          step_d = '0;
          if (last_q) cmd_o.op = xxh_pkg::OP_MSTART;
        end else begin
          cmd_o.op = xxh_pkg::OP_WRITE;
          cmd_o.byte_val = data_q[7:0];
          data_d = data_q >> 8;
          idx_d = idx_q + 4'd1;
        end
      end
      S_ROUND: begin
        cmd_o.lane = step_q[2:1];
        cmd_o.op = step_q[0] ? xxh_pkg::OP_RFIN : xxh_pkg::OP_RMUL;
        step_d = step_q + 4'd1;
        if (step_q == 4'd7) state_d = S_BYTE;
      end
      S_MERGE: begin
        if (!status_i.long_msg) begin
          cmd_o.op = xxh_pkg::OP_LEN;
          state_d = S_W8;
          step_d = '0;
        end else begin
          cmd_o.lane = step_q[3:2];
          cmd_o.phase = {1'b0, step_q[1]};
          cmd_o.op = (step_q[1:0] == 2'd0) ? xxh_pkg::OP_MMUL :
                     (step_q[1:0] == 2'd3) ? xxh_pkg::OP_NONE : xxh_pkg::OP_MFIN;
          step_d = step_q + 4'd1;
          if (step_q == 4'd15) begin
            state_d = S_W8;
            cmd_o.op = xxh_pkg::OP_LEN;
          end
        end
      end
      S_W8: begin
        if (status_i.pos + 6'd8 <= tail) begin
          cmd_o.op = (step_q == 4'd0) ? xxh_pkg::OP_W8A :
                     (step_q == 4'd1) ? xxh_pkg::OP_W8B : xxh_pkg::OP_W8C;
          step_d = (step_q == 4'd2) ? 4'd0 : step_q + 4'd1;
        end else begin
          state_d = S_W4;
          step_d = '0;
        end
      end
      S_W4: begin
        if (status_i.pos + 6'd4 <= tail) begin
          cmd_o.op = xxh_pkg::OP_W4;
          cmd_o.phase = {1'b0, step_q[0]};
          step_d = step_q + 4'd1;
          if (step_q[0]) state_d = S_B1;
        end else state_d = S_B1;
        if (state_d == S_B1) step_d = '0;
      end
      S_B1: begin
        if (status_i.pos < tail) begin
          cmd_o.op = xxh_pkg::OP_B1;
          cmd_o.phase = {1'b0, step_q[0]};
          step_d = {3'd0, ~step_q[0]};
        end else begin
          state_d = S_AVA;
          step_d = '0;
        end
      end
      S_AVA: begin
        cmd_o.op = xxh_pkg::OP_AVA;
        cmd_o.phase = step_q[1:0];
        step_d = step_q + 4'd1;
        if (step_q == 4'd2) state_d = S_OUT;
      end
      S_OUT: begin
        // The hash moves on as soon as the output register is free.
        if (!out_valid_q || out_ch.ready) begin
          cmd_o.op = xxh_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
          init_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      step_q  <= '0;
      init_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      // While a product is in progress the sequence holds its place.
      if (!mul_busy_i) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
        idx_q   <= idx_d;
        last_q  <= last_d;
        step_q  <= step_d;
        init_q  <= init_d;
      end
    end
  end

  always_ff @(posedge clk_i) data_q <= data_d;

endmodule

### src/xxhash64_stream_hash.sv
// ----------------------------------------------------------------------------
// xxhash64_stream_hash
// Streaming XXH64 over items of up to eight little-endian bytes.
// ----------------------------------------------------------------------------
// An item is accepted while the sequencer is idle; its valid bytes are then
// written into the stripe buffer in order, and a closing step follows before
// the next one can be accepted. Every 64-bit product is built from partial
// products of a single 32x32 multiplier while the sequencer waits. Each time a
// 32-byte stripe is complete, the sequencer runs the four lane rounds of two
// products each. The last item also runs the digest: the lane merge for a
// message of 32 bytes or more, the length add, each remaining 8-byte word, any
// remaining 4-byte word, each trailing byte, the avalanche and the copy of the
// hash into the output register, which holds it until taken. The lanes are then
// reloaded from the seed before the next item is accepted; the input stalls on
// the output only when a new hash is ready while the previous one still waits.
// A seed write that comes while the sequencer is idle and no byte of a message
// has arrived yet reloads the lanes.
module xxhash64_stream_hash #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  xxh_in_if.sink      in_ch,
  xxh_out_if.source   out_ch
);

  logic [63:0]      seed_q;
  xxh_pkg::cmd_t    cmd;
  xxh_pkg::status_t status;
  logic             mul_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= '0;
    else if (cfg_we_i) seed_q <= cfg_wdata_i;
  end

  xxh_ctrl #(.BYTES_PER_ITEM(BYTES_PER_ITEM)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .in_ch, .out_ch,
    .status_i(status), .mul_busy_i(mul_busy), .cmd_o(cmd)
  );

  xxh_datapath u_dp (
    .clk_i, .rst_ni, .seed_i(seed_q), .cmd_i(cmd), .status_o(status),
    .busy_o(mul_busy), .hash_o(out_ch.hash_value)
  );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming XXH64 block. A local hash model
// predicts each digest; random valid/ready gaps and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic        last;
  } msg_item_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [63:0] cfg_wdata_i;

  xxh_in_if  in_ch ();
  xxh_out_if out_ch ();

  xxhash64_stream_hash u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Hash model state.
  logic [63:0] seed_reg, msg_seed;
  logic [63:0] lanes [4];
  logic [7:0]  stripe [32];
  int unsigned stripe_fill;
  logic [63:0] msg_len;

  msg_item_t   pending_q [$];
  logic [63:0] hash_q [$];
  int          errors;
  int          idle_cycles;
  bit          quiet_phase;
  int          hold_off;

  function automatic logic [63:0] rol(logic [63:0] x, int r);
    return (r == 0) ? x : ((x << r) | (x >> (64 - r)));
  endfunction

  function automatic logic [63:0] mix_round(logic [63:0] acc, logic [63:0] w);
    acc = acc + w * xxh_pkg::P2;
    return rol(acc, 31) * xxh_pkg::P1;
  endfunction

  function automatic logic [63:0] load_bytes(int pos, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v |= 64'(stripe[(pos + i) & 31]) << (8 * i);
    return v;
  endfunction

  task automatic init_message();
    msg_seed = seed_reg;
    lanes[0] = msg_seed + xxh_pkg::P1 + xxh_pkg::P2;
    lanes[1] = msg_seed + xxh_pkg::P2;
    lanes[2] = msg_seed;
    lanes[3] = msg_seed - xxh_pkg::P1;
    foreach (stripe[i]) stripe[i] = '0;
    stripe_fill = 0;
    msg_len = '0;
  endtask

  function automatic logic [63:0] digest();
    logic [63:0] h;
    int pos, stop;
    pos = 0;
    stop = stripe_fill;
    if (msg_len >= 32) begin
      h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
      for (int k = 0; k < 4; k++)
        h = (h ^ mix_round('0, lanes[k])) * xxh_pkg::P1 + xxh_pkg::P4;
    end else begin
      h = msg_seed + xxh_pkg::P5;
    end
    h += msg_len;
    while (pos + 8 <= stop) begin
      h ^= mix_round('0, load_bytes(pos, 8));
      h = rol(h, 27) * xxh_pkg::P1 + xxh_pkg::P4;
      pos += 8;
    end
    if (pos + 4 <= stop) begin
      h ^= load_bytes(pos, 4) * xxh_pkg::P1;
      h = rol(h, 23) * xxh_pkg::P2 + xxh_pkg::P3;
      pos += 4;
    end
    while (pos < stop) begin
      h ^= 64'(stripe[pos]) * xxh_pkg::P5;
      h = rol(h, 11) * xxh_pkg::P1;
      pos++;
    end
    h ^= h >> 33; h *= xxh_pkg::P2;
    h ^= h >> 29; h *= xxh_pkg::P3;
    h ^= h >> 32;
    return h;
  endfunction

  task automatic absorb_item(msg_item_t it);
    int n;
    n = (it.cnt > 8) ? 8 : it.cnt;
    msg_len += n;
    for (int i = 0; i < n; i++) begin
      stripe[stripe_fill] = it.data[8*i +: 8];
      stripe_fill++;
      if (stripe_fill == 32) begin
        for (int k = 0; k < 4; k++) lanes[k] = mix_round(lanes[k], load_bytes(8 * k, 8));
        stripe_fill = 0;
      end
    end
    if (it.last) begin
      hash_q.push_back(digest());
      init_message();
    end
  endtask

  task automatic queue_item(logic [63:0] d, logic [3:0] c, logic l);
    msg_item_t it;
    it.data = d; it.cnt = c; it.last = l;
    pending_q.push_back(it);
  endtask

  // A message of exactly nbytes bytes, split into random-sized items.
  task automatic queue_message(int nbytes);
    int c;
    while (nbytes > 8) begin
      c = $urandom_range(0, 8);
      queue_item({$urandom, $urandom}, 4'(c), 1'b0);
      nbytes -= c;
    end
    queue_item({$urandom, $urandom}, 4'(nbytes), 1'b1);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || hash_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [63:0] s);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    seed_reg = s;
    if (msg_len == 0 && stripe_fill == 0) init_message();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data_bytes <= '0;
      in_ch.byte_count <= '0;
      in_ch.last_item <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_item(pending_q.pop_front());
      end
      if ((!in_ch.valid || in_ch.ready) && pending_q.size() != 0 &&
          (quiet_phase || $urandom_range(0, 99) >= 12)) begin
        in_ch.valid <= 1'b1;
        in_ch.data_bytes <= pending_q[0].data;
        in_ch.byte_count <= pending_q[0].cnt;
        in_ch.last_item <= pending_q[0].last;
      end else if (in_ch.valid && in_ch.ready) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor and output stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hash_q.size() == 0) begin
          $display("%0t: unexpected hash %h", $time, out_ch.hash_value);
          errors++;
        end else begin
          if (out_ch.hash_value !== hash_q[0]) begin
            $display("%0t: hash mismatch expected %h actual %h", $time, hash_q[0],
                     out_ch.hash_value);
            errors++;
          end
          void'(hash_q.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet_phase || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    errors = 0; idle_cycles = 0; quiet_phase = 0; hold_off = 0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    seed_reg = '0;
    init_message();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, extremes, oversized counts, short and long paths.
    queue_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
    queue_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    queue_item(64'h0, 4'd8, 1'b1);
    queue_item(64'hA5A5_5A5A_0123_4567, 4'd15, 1'b1);
    queue_item(64'h0123_4567_89AB_CDEF, 4'd9, 1'b0);
    queue_item(64'hFEDC_BA98_7654_3210, 4'd3, 1'b1);
    for (int i = 0; i < 5; i++) queue_item({$urandom, $urandom}, 4'd8, 1'b0);
    queue_item({$urandom, $urandom}, 4'd7, 1'b1);
    for (int i = 0; i < 4; i++) queue_item({$urandom, $urandom}, 4'd8, 1'b0);
    queue_item(64'h0, 4'd0, 1'b1);
    drain();

    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    queue_message(0); queue_message(5); queue_message(40);
    drain();

    // Seed written mid-message applies from the next message.
    queue_item({$urandom, $urandom}, 4'd4, 1'b0);
    drain();
    write_seed({$urandom, $urandom});
    queue_item({$urandom, $urandom}, 4'd6, 1'b1);
    queue_message(20);
    drain();

    // Long output hold-off while inputs keep coming.
    hold_off = 400;
    for (int m = 0; m < 6; m++) queue_message($urandom_range(0, 70));
    drain();

    write_seed(64'h0);
    for (int m = 0; m < 20; m++) queue_message($urandom_range(0, 80));
    drain();

    quiet_phase = 1;
    for (int m = 0; m < 15; m++) queue_message($urandom_range(0, 60));
    drain();
    quiet_phase = 0;

    for (int p = 0; p < 3; p++) begin
      write_seed({$urandom, $urandom});
      for (int m = 0; m < 5; m++) queue_message($urandom_range(0, 90));
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/xxh_pkg.sv
src/xxh_if.sv
src/xxh_datapath.sv
src/xxh_ctrl.sv
src/xxhash64_stream_hash.sv
sim/tb_top.sv
